// ===== hdl/kbmt_pkg.sv =====
// ----------------------------------------------------------------------------
// kbmt_pkg
// Shared sizes, codes and types of the key binding match table.
// ----------------------------------------------------------------------------
package kbmt_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (CNT_W > 8) ? CNT_W : 8;

    localparam int OPC_W  = 2;
    localparam int KEY_W  = 8;
    localparam int MOD_W  = 8;
    localparam int ACT_W  = 5;
    localparam int SLOT_W = 8;
    localparam int STS_W  = 2;
    localparam int SOUT_W = 5;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } t_opcode;

    typedef enum logic [STS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_SLOT  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RM_RD,
        S_RM_WR,
        S_LK_RD,
        S_LK_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [MOD_W-1:0] mods;
        logic [ACT_W-1:0] act;
    } t_entry;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [KEY_W-1:0]  key;
        logic [MOD_W-1:0]  mods;
        logic [ACT_W-1:0]  act;
        logic [SLOT_W-1:0] slot;
    } t_request;

    typedef struct packed {
        t_status           status;
        logic [SOUT_W-1:0] slot;
        logic [ACT_W-1:0]  act;
    } t_result;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

endpackage

// ===== hdl/kbmt_if.sv =====
// ----------------------------------------------------------------------------
// kbmt_if
// Request and response channels of the key binding match table.
// ----------------------------------------------------------------------------
interface kbmt_req_if;
    logic                       valid;
    logic                       ready;
    logic [kbmt_pkg::OPC_W-1:0]  opcode;
    logic [kbmt_pkg::KEY_W-1:0]  key_code;
    logic [kbmt_pkg::MOD_W-1:0]  modifier_bits;
    logic [kbmt_pkg::ACT_W-1:0]  action_code;
    logic [kbmt_pkg::SLOT_W-1:0] slot_number;

    modport source (
        output valid, opcode, key_code, modifier_bits, action_code, slot_number,
        input  ready
    );
    modport sink (
        input  valid, opcode, key_code, modifier_bits, action_code, slot_number,
        output ready
    );
endinterface

interface kbmt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [kbmt_pkg::STS_W-1:0]  status;
    logic [kbmt_pkg::SOUT_W-1:0] slot_out;
    logic [kbmt_pkg::ACT_W-1:0]  action_out;

    modport source (
        output valid, status, slot_out, action_out,
        input  ready
    );
    modport sink (
        input  valid, status, slot_out, action_out,
        output ready
    );
endinterface

// ===== hdl/kbmt_store.sv =====
// ----------------------------------------------------------------------------
// kbmt_store
// Binding memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module kbmt_store (
    input  logic               i_clk,
    input  kbmt_pkg::t_mem_req i_mem,
    output kbmt_pkg::t_entry   o_rd_data
);

    kbmt_pkg::t_entry r_mem [kbmt_pkg::ENTRIES];
    kbmt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_mem.wr_addr] <= i_mem.wr_data;
        end
        if (i_mem.rd_en) begin
            r_rd_data <= r_mem[i_mem.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/kbmt_seq.sv =====
// ----------------------------------------------------------------------------
// kbmt_seq
// Sequencer: decodes a request, walks the table one slot per step through a
// shared increment and compare, and holds the response register.
// ----------------------------------------------------------------------------
module kbmt_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    kbmt_req_if.sink           i_req,
    kbmt_rsp_if.source         o_rsp,
    output kbmt_pkg::t_mem_req o_mem,
    input  kbmt_pkg::t_entry   i_rd_data
);

    kbmt_pkg::t_state   r_state, n_state;
    kbmt_pkg::t_request r_req;
    logic [kbmt_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [kbmt_pkg::IDX_W-1:0] r_dst, n_dst;
    logic [kbmt_pkg::CNT_W-1:0] r_count, n_count;
    kbmt_pkg::t_result  r_res, n_res;
    kbmt_pkg::t_result  r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [kbmt_pkg::CNT_W-1:0] w_op_a;
    logic [kbmt_pkg::CNT_W-1:0] w_sum;
    logic                       w_more;
    logic                       w_full;
    logic                       w_slot_bad;
    logic                       w_match;
    logic                       w_accept;
    logic                       w_out_free;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_full     = (r_count == kbmt_pkg::CNT_W'(kbmt_pkg::ENTRIES));
    assign w_slot_bad = (kbmt_pkg::CMP_W'(r_req.slot) >= kbmt_pkg::CMP_W'(r_count));
    assign w_match    = (i_rd_data.key == r_req.key) && (i_rd_data.mods == r_req.mods);

    // shared step unit: next index and bound check
    always_comb begin
        if (r_state == kbmt_pkg::S_DECODE) begin
            w_op_a = kbmt_pkg::CNT_W'(r_req.slot);
        end else begin
            w_op_a = kbmt_pkg::CNT_W'(r_idx);
        end
    end
    assign w_sum  = w_op_a + kbmt_pkg::CNT_W'(1);
    assign w_more = (w_sum < r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kbmt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = kbmt_pkg::S_DECODE;
                end
            end
            kbmt_pkg::S_DECODE: begin
                unique case (r_req.opcode)
                    kbmt_pkg::OP_REMOVE: begin
                        if (!w_slot_bad && w_more) begin
                            n_state = kbmt_pkg::S_RM_RD;
                        end else begin
                            n_state = kbmt_pkg::S_DONE;
                        end
                    end
                    kbmt_pkg::OP_LOOKUP: begin
                        if (r_count != '0) begin
                            n_state = kbmt_pkg::S_LK_RD;
                        end else begin
                            n_state = kbmt_pkg::S_DONE;
                        end
                    end
                    default: n_state = kbmt_pkg::S_DONE;
                endcase
            end
            kbmt_pkg::S_RM_RD: n_state = kbmt_pkg::S_RM_WR;
            kbmt_pkg::S_RM_WR: begin
                n_state = w_more ? kbmt_pkg::S_RM_RD : kbmt_pkg::S_DONE;
            end
            kbmt_pkg::S_LK_RD: n_state = kbmt_pkg::S_LK_CMP;
            kbmt_pkg::S_LK_CMP: begin
                if (!w_match && w_more) begin
                    n_state = kbmt_pkg::S_LK_RD;
                end else begin
                    n_state = kbmt_pkg::S_DONE;
                end
            end
            kbmt_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = kbmt_pkg::S_IDLE;
                end
            end
            default: n_state = kbmt_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_idx         = r_idx;
        n_dst         = r_dst;
        n_count       = r_count;
        n_res         = r_res;
        n_out         = r_out;
        n_out_valid   = r_out_valid;
        o_mem         = '0;
        o_mem.wr_data = r_req.act == '0 ? i_rd_data : i_rd_data;
        unique case (r_state)
            kbmt_pkg::S_DECODE: begin
                n_res = '{status: kbmt_pkg::ST_OK, slot: '0, act: '0};
                unique case (r_req.opcode)
                    kbmt_pkg::OP_ADD: begin
                        if (w_full) begin
                            n_res.status = kbmt_pkg::ST_FULL;
                        end else begin
                            o_mem.wr_en   = 1'b1;
                            o_mem.wr_addr = r_count[kbmt_pkg::IDX_W-1:0];
                            o_mem.wr_data = '{key: r_req.key, mods: r_req.mods,
                                              act: r_req.act};
                            n_res.slot    = kbmt_pkg::SOUT_W'(r_count);
                            n_count       = r_count + kbmt_pkg::CNT_W'(1);
                        end
                    end
                    kbmt_pkg::OP_REMOVE: begin
                        if (w_slot_bad) begin
                            n_res.status = kbmt_pkg::ST_BAD_SLOT;
                        end else begin
                            n_dst = kbmt_pkg::IDX_W'(r_req.slot);
                            n_idx = kbmt_pkg::IDX_W'(w_sum);
                            if (!w_more) begin
                                n_count = r_count - kbmt_pkg::CNT_W'(1);
                            end
                        end
                    end
                    kbmt_pkg::OP_LOOKUP: begin
                        n_idx = '0;
                        if (r_count == '0) begin
                            n_res.status = kbmt_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: n_res.status = kbmt_pkg::ST_NOT_FOUND;
                endcase
            end
            kbmt_pkg::S_RM_RD, kbmt_pkg::S_LK_RD: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_idx;
            end
            kbmt_pkg::S_RM_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_dst;
                o_mem.wr_data = i_rd_data;
                n_dst         = r_idx;
                n_idx         = kbmt_pkg::IDX_W'(w_sum);
                if (!w_more) begin
                    n_count = r_count - kbmt_pkg::CNT_W'(1);
                end
            end
            kbmt_pkg::S_LK_CMP: begin
                if (w_match) begin
                    n_res = '{status: kbmt_pkg::ST_OK,
                              slot: kbmt_pkg::SOUT_W'(r_idx),
                              act: i_rd_data.act};
                end else if (w_more) begin
                    n_idx = kbmt_pkg::IDX_W'(w_sum);
                end else begin
                    n_res = '{status: kbmt_pkg::ST_NOT_FOUND, slot: '0, act: '0};
                end
            end
            default: begin
            end
        endcase
        // hold the response until taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == kbmt_pkg::S_DONE && w_out_free) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kbmt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= '{opcode: i_req.opcode, key: i_req.key_code,
                       mods: i_req.modifier_bits, act: i_req.action_code,
                       slot: i_req.slot_number};
        end
        r_idx <= n_idx;
        r_dst <= n_dst;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign i_req.ready      = (r_state == kbmt_pkg::S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.slot_out   = r_out.slot;
    assign o_rsp.action_out = r_out.act;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kbmt_pkg::CNT_W'(kbmt_pkg::ENTRIES))
        else $error("entry count exceeds table depth");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kbmt_pkg::S_DECODE && r_req.opcode == kbmt_pkg::OP_ADD && !w_full)
        |=> r_count == $past(r_count) + kbmt_pkg::CNT_W'(1))
        else $error("add did not grow the table");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en |-> (r_state == kbmt_pkg::S_DECODE || r_state == kbmt_pkg::S_RM_WR))
        else $error("memory write outside add or shift");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kbmt_pkg::S_LK_RD || r_state == kbmt_pkg::S_RM_RD)
        |-> kbmt_pkg::CNT_W'(r_idx) < r_count)
        else $error("table walk past last entry");
`endif

endmodule

// ===== hdl/key_binding_match_table.sv =====
// ----------------------------------------------------------------------------
// key_binding_match_table
// Associative table of (key code, modifier mask) to action code bindings.
// ----------------------------------------------------------------------------
// Channels: i_req carries one request (add, remove at slot, lookup); o_rsp
// returns exactly one response per request with status, slot and action.
// Both use valid/ready; a request moves at a clock edge with both high.
// Add, bad remove, lookup on an empty table and unused opcodes finish
// without a table walk; remove at slot s shifts each later entry down
// one slot; lookup walks from slot 0 until a match or the last entry.
// One request is in work at a time; the walk uses the single read port of
// the binding memory, a read step per slot, then a compare or move step.
// i_req.ready is high only while the sequencer is idle. A finished response
// sits in the output register while the receiver stalls; the next request
// is accepted meanwhile, and its response waits until that register frees.
// Reset clears the entry count and the response valid flag; the binding
// memory needs no clearing, since only slots below the count are read.
// ----------------------------------------------------------------------------
module key_binding_match_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kbmt_req_if.sink   i_req,
    kbmt_rsp_if.source o_rsp
);

    kbmt_pkg::t_mem_req w_mem;
    kbmt_pkg::t_entry   w_rd_data;

    kbmt_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mem     (w_mem),
        .i_rd_data (w_rd_data)
    );

    kbmt_store u_store (
        .i_clk     (i_clk),
        .i_mem     (w_mem),
        .o_rd_data (w_rd_data)
    );

endmodule
